[rtl/core/acld_pkg.sv]
// Shared types, character codes and helpers for the ASCII command-line decoder.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package acld_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 32;

    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
    localparam logic [4:0]  FRAC_MAX = 5'd31;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LS    = 8'h73;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Command words, left aligned and padded with spaces to five characters.
    localparam logic [39:0] WORD_CAL   = "cal  ";
    localparam logic [39:0] WORD_REV   = "rev  ";
    localparam logic [39:0] WORD_DPING = "dping";
    localparam logic [39:0] WORD_DSCAN = "dscan";
    localparam logic [39:0] WORD_DIR   = "dir  ";
    localparam logic [39:0] WORD_WD    = "wd   ";

    // Result kinds.
    localparam logic [3:0] KIND_STOP     = 4'd0;
    localparam logic [3:0] KIND_CAL      = 4'd1;
    localparam logic [3:0] KIND_REV      = 4'd2;
    localparam logic [3:0] KIND_DPING    = 4'd3;
    localparam logic [3:0] KIND_DSCAN    = 4'd4;
    localparam logic [3:0] KIND_DIRPWM   = 4'd5;
    localparam logic [3:0] KIND_STEER    = 4'd6;
    localparam logic [3:0] KIND_SPEED    = 4'd7;
    localparam logic [3:0] KIND_PWM      = 4'd8;
    localparam logic [3:0] KIND_WATCHDOG = 4'd9;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_FIXED,
        DEC_NUM
    } dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_DECIDE,
        ST_NUM_RD,
        ST_NUM_EV,
        ST_NUM_END,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic store;
        logic clear_len;
        logic scan_start;
        logic rd;
        logic scan_eval;
        logic decide;
        logic num_eval;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic len_zero;
        logic full;
        logic scan_last;
        dec_t dec;
        logic num_break;
        logic num_last;
        logic num_ok;
        logic out_free;
    } sts_t;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UA && b <= CH_UZ) begin
            r = b | 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] word_char(input logic [39:0] w, input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = w[39:32];
            3'd1:    c = w[31:24];
            3'd2:    c = w[23:16];
            3'd3:    c = w[15:8];
            default: c = w[7:0];
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/acld_ctrl.sv]
// Controller state machine of the command-line decoder: sequences byte storage,
// header scan, number parse and result hand-off. Depends on acld_pkg.
`default_nettype none

module acld_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire acld_pkg::sts_t sts,
    output acld_pkg::cmd_t     cmd
);

    acld_pkg::state_t state_reg;
    acld_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acld_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acld_pkg::ST_IDLE:
            begin
                if (accept && sts.is_lf && !sts.len_zero)
                begin
                    state_next = acld_pkg::ST_SCAN_RD;
                end
            end
            acld_pkg::ST_SCAN_RD: state_next = acld_pkg::ST_SCAN_EV;
            acld_pkg::ST_SCAN_EV:
            begin
                state_next = sts.scan_last ? acld_pkg::ST_DECIDE : acld_pkg::ST_SCAN_RD;
            end
            acld_pkg::ST_DECIDE:
            begin
                case (sts.dec)
                    acld_pkg::DEC_FIXED: state_next = acld_pkg::ST_EMIT;
                    acld_pkg::DEC_NUM:   state_next = acld_pkg::ST_NUM_RD;
                    default:             state_next = acld_pkg::ST_IDLE;
                endcase
            end
            acld_pkg::ST_NUM_RD: state_next = acld_pkg::ST_NUM_EV;
            acld_pkg::ST_NUM_EV:
            begin
                state_next = (sts.num_break || sts.num_last) ? acld_pkg::ST_NUM_END
                                                             : acld_pkg::ST_NUM_RD;
            end
            acld_pkg::ST_NUM_END:
            begin
                state_next = sts.num_ok ? acld_pkg::ST_EMIT : acld_pkg::ST_IDLE;
            end
            acld_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = acld_pkg::ST_IDLE;
                end
            end
            default: state_next = acld_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            acld_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (sts.is_cr)
                    begin
                        cmd = '0;
                    end
                    else if (sts.is_lf)
                    begin
                        cmd.clear_len  = sts.len_zero;
                        cmd.scan_start = !sts.len_zero;
                    end
                    else if (sts.full)
                    begin
                        // A byte that finds the store full discards the line and itself.
                        cmd.clear_len = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            acld_pkg::ST_SCAN_RD: cmd.rd = 1'b1;
            acld_pkg::ST_SCAN_EV: cmd.scan_eval = 1'b1;
            acld_pkg::ST_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.clear_len = (sts.dec != acld_pkg::DEC_FIXED) &&
                                (sts.dec != acld_pkg::DEC_NUM);
            end
            acld_pkg::ST_NUM_RD: cmd.rd = 1'b1;
            acld_pkg::ST_NUM_EV: cmd.num_eval = 1'b1;
            acld_pkg::ST_NUM_END: cmd.clear_len = !sts.num_ok;
            acld_pkg::ST_EMIT:
            begin
                cmd.emit      = sts.out_free;
                cmd.clear_len = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/acld_datapath.sv]
// Datapath of the command-line decoder: line store memory, length and index,
// header match flags, decimal number accumulator and result register. Depends on acld_pkg.
`default_nettype none

module acld_datapath
#(
    parameter int LINE_BUFFER_BYTES = acld_pkg::LINE_BUFFER_BYTES_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    rx_byte,
    input  wire acld_pkg::cmd_t cmd,
    output acld_pkg::sts_t     sts,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [3:0]         command_kind,
    output logic signed [31:0] value_mantissa,
    output logic [4:0]         fraction_digits,
    output logic               value_saturated
);

    localparam int DEPTH = LINE_BUFFER_BYTES - 1;
    localparam int LW    = $clog2(LINE_BUFFER_BYTES);
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] scan_lim;

    logic [7:0] first_reg;
    logic [7:0] b2_reg;
    logic       m_cal_reg, m_rev_reg, m_dping_reg, m_dscan_reg, m_dir_reg, m_wd_reg;

    logic [3:0]  kind_reg;
    logic        lead_reg, neg_reg, point_reg, sat_reg, dig_reg;
    logic [30:0] mag_reg;
    logic [4:0]  frac_reg;

    logic        out_valid_reg;
    logic [3:0]  kind_out_reg;
    logic [31:0] mant_out_reg;
    logic [4:0]  frac_out_reg;
    logic        sat_out_reg;

    logic [7:0]    fb;
    logic [2:0]    pos;
    acld_pkg::dec_t dec;
    logic [3:0]    dec_kind;
    logic [LW-1:0] dec_start;

    logic        is_blank, is_sign, is_digit, is_point;
    logic [3:0]  dsub;
    logic [34:0] mag_ext;
    logic [34:0] t_sum;
    logic        over;
    logic [30:0] mag_next;
    logic [31:0] mag_wide;

    // Line store: single write port from the input byte, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[len_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd.clear_len)
        begin
            len_reg <= '0;
        end
        else if (cmd.store)
        begin
            len_reg <= len_reg + LW'(1);
        end
    end

    assign fb       = acld_pkg::fold(rd_data_reg);
    assign pos      = idx_reg[2:0];
    assign scan_lim = (len_reg > LW'(5)) ? LW'(5) : len_reg;

    // Priority decision over the header flags once the first bytes are scanned.
    always_comb
    begin
        dec       = acld_pkg::DEC_NONE;
        dec_kind  = acld_pkg::KIND_STOP;
        dec_start = LW'(1);
        if (first_reg == acld_pkg::CH_LX)
        begin
            dec = acld_pkg::DEC_FIXED;
        end
        else if (m_cal_reg && len_reg >= LW'(3))
        begin
            dec      = acld_pkg::DEC_FIXED;
            dec_kind = acld_pkg::KIND_CAL;
        end
        else if (m_rev_reg && len_reg >= LW'(3))
        begin
            dec      = acld_pkg::DEC_FIXED;
            dec_kind = acld_pkg::KIND_REV;
        end
        else if (m_dping_reg && len_reg >= LW'(5))
        begin
            dec      = acld_pkg::DEC_FIXED;
            dec_kind = acld_pkg::KIND_DPING;
        end
        else if (m_dscan_reg && len_reg >= LW'(5))
        begin
            dec      = acld_pkg::DEC_FIXED;
            dec_kind = acld_pkg::KIND_DSCAN;
        end
        else if (m_dir_reg && len_reg >= LW'(4))
        begin
            dec       = acld_pkg::DEC_NUM;
            dec_kind  = acld_pkg::KIND_DIRPWM;
            dec_start = LW'(3);
        end
        else if ((first_reg == acld_pkg::CH_LS || first_reg == acld_pkg::CH_LV ||
                  first_reg == acld_pkg::CH_LP) && len_reg >= LW'(2))
        begin
            dec = acld_pkg::DEC_NUM;
            if (first_reg == acld_pkg::CH_LS)
            begin
                dec_kind = acld_pkg::KIND_STEER;
            end
            else if (first_reg == acld_pkg::CH_LV)
            begin
                dec_kind = acld_pkg::KIND_SPEED;
            end
            else
            begin
                dec_kind = acld_pkg::KIND_PWM;
            end
        end
        else if (m_wd_reg && len_reg >= LW'(3))
        begin
            dec      = acld_pkg::DEC_FIXED;
            dec_kind = acld_pkg::KIND_WATCHDOG;
        end
    end

    // Number byte classification on the raw stored byte.
    assign is_blank = (rd_data_reg == acld_pkg::CH_SPACE) || (rd_data_reg == acld_pkg::CH_TAB) ||
                      (rd_data_reg == acld_pkg::CH_VT)    || (rd_data_reg == acld_pkg::CH_FF);
    assign is_sign  = (rd_data_reg == acld_pkg::CH_PLUS) || (rd_data_reg == acld_pkg::CH_MINUS);
    assign is_digit = (rd_data_reg >= acld_pkg::CH_ZERO) && (rd_data_reg <= acld_pkg::CH_NINE);
    assign is_point = (rd_data_reg == acld_pkg::CH_POINT) && !point_reg;
    assign dsub     = 4'(rd_data_reg - acld_pkg::CH_ZERO);

    assign mag_ext  = {4'b0, mag_reg};
    assign t_sum    = (mag_ext << 3) + (mag_ext << 1) + {31'b0, dsub};
    assign over     = t_sum > {4'b0, acld_pkg::MAG_MAX};
    assign mag_next = over ? acld_pkg::MAG_MAX : t_sum[30:0];
    assign mag_wide = {1'b0, mag_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            idx_reg     <= '0;
            m_cal_reg   <= 1'b1;
            m_rev_reg   <= 1'b1;
            m_dping_reg <= 1'b1;
            m_dscan_reg <= 1'b1;
            m_dir_reg   <= 1'b1;
            m_wd_reg    <= 1'b1;
        end
        else if (cmd.scan_eval)
        begin
            idx_reg     <= idx_reg + LW'(1);
            m_cal_reg   <= m_cal_reg &&
                           (pos >= 3'd3 || fb == acld_pkg::word_char(acld_pkg::WORD_CAL, pos));
            m_rev_reg   <= m_rev_reg &&
                           (pos >= 3'd3 || fb == acld_pkg::word_char(acld_pkg::WORD_REV, pos));
            m_dping_reg <= m_dping_reg &&
                           (fb == acld_pkg::word_char(acld_pkg::WORD_DPING, pos));
            m_dscan_reg <= m_dscan_reg &&
                           (fb == acld_pkg::word_char(acld_pkg::WORD_DSCAN, pos));
            m_dir_reg   <= m_dir_reg &&
                           (pos >= 3'd3 || fb == acld_pkg::word_char(acld_pkg::WORD_DIR, pos));
            m_wd_reg    <= m_wd_reg &&
                           (pos >= 3'd2 || fb == acld_pkg::word_char(acld_pkg::WORD_WD, pos));
            if (pos == 3'd0)
            begin
                first_reg <= fb;
            end
            if (pos == 3'd2)
            begin
                b2_reg <= rd_data_reg;
            end
        end
        else if (cmd.decide)
        begin
            idx_reg   <= dec_start;
            kind_reg  <= dec_kind;
            lead_reg  <= 1'b1;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            sat_reg   <= 1'b0;
            dig_reg   <= 1'b0;
            frac_reg  <= '0;
            // The watchdog command carries its flag in the magnitude.
            mag_reg   <= (dec_kind == acld_pkg::KIND_WATCHDOG) ?
                         {30'b0, (b2_reg != acld_pkg::CH_ZERO)} : '0;
        end
        else if (cmd.num_eval)
        begin
            idx_reg  <= idx_reg + LW'(1);
            lead_reg <= lead_reg && is_blank;
            if (lead_reg && is_blank)
            begin
                neg_reg <= neg_reg;
            end
            else if (lead_reg && is_sign)
            begin
                neg_reg <= (rd_data_reg == acld_pkg::CH_MINUS);
            end
            else if (is_digit)
            begin
                mag_reg <= mag_next;
                sat_reg <= sat_reg || over;
                dig_reg <= 1'b1;
                if (point_reg && frac_reg != acld_pkg::FRAC_MAX)
                begin
                    frac_reg <= frac_reg + 5'd1;
                end
            end
            else if (is_point)
            begin
                point_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_out_reg <= kind_reg;
            mant_out_reg <= neg_reg ? (32'd0 - mag_wide) : mag_wide;
            frac_out_reg <= frac_reg;
            sat_out_reg  <= sat_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign command_kind    = kind_out_reg;
    assign value_mantissa  = mant_out_reg;
    assign fraction_digits = frac_out_reg;
    assign value_saturated = sat_out_reg;

    assign sts.is_cr     = (rx_byte == acld_pkg::CH_CR);
    assign sts.is_lf     = (rx_byte == acld_pkg::CH_LF);
    assign sts.len_zero  = (len_reg == '0);
    assign sts.full      = (len_reg == LW'(DEPTH));
    assign sts.scan_last = (idx_reg == scan_lim - LW'(1));
    assign sts.dec       = dec;
    assign sts.num_break = !(lead_reg && (is_blank || is_sign)) && !is_digit && !is_point;
    assign sts.num_last  = (idx_reg == len_reg - LW'(1));
    assign sts.num_ok    = dig_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result loaded while previous result still held");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (len_reg != LW'(DEPTH)))
        else $error("byte stored into a full line store");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (idx_reg < len_reg))
        else $error("line store read beyond stored length");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && len_reg == '0))
        else $error("result transfer did not leave an empty line and a valid result");

endmodule

`default_nettype wire

[rtl/core/ascii_command_line_decoder_core.sv]
// Top level of the ASCII command-line decoder: joins controller and datapath.
// Depends on acld_pkg, acld_ctrl and acld_datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   input   | in        | in_valid / in_stall   | rx_byte
//   result  | out       | out_valid / out_stall | command_kind, value_mantissa,
//           |           |                      | fraction_digits, value_saturated
//
// A CR or an ordinary byte is taken without a stall. An LF after a non-empty line decodes it
// through the single read port of the line store, each byte read and then evaluated: min(L, 5)
// header bytes, a decision state, then up to L - 1 number bytes, an end state and a hand-off
// state. in_stall stays high from after the LF until the decode ends, and the hand-off also
// waits on out_stall.
// Reset clears the line length, controller and result valid at once; the store is not cleared.
// in_stall is high while a line is being decoded; out_stall only holds the result register,
// and a new decode waits in its hand-off state until the previous result is transferred.
`default_nettype none

module ascii_command_line_decoder_core
#(
    parameter int LINE_BUFFER_BYTES = acld_pkg::LINE_BUFFER_BYTES_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [3:0]         command_kind,
    output logic signed [31:0] value_mantissa,
    output logic [4:0]         fraction_digits,
    output logic               value_saturated
);

    acld_pkg::cmd_t cmd;
    acld_pkg::sts_t sts;

    acld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    acld_datapath
    #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (rx_byte),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .command_kind    (command_kind),
        .value_mantissa  (value_mantissa),
        .fraction_digits (fraction_digits),
        .value_saturated (value_saturated)
    );

endmodule

`default_nettype wire
